// ===== hdl/ppm_pkg.sv =====
// Shared widths, register indexes, drive levels and reset values of the phased position move.
`default_nettype none
package ppm_pkg;

    localparam int POS_W    = 32;
    localparam int WIN_W    = 16;
    localparam int CNT_W    = 8;
    localparam int PCT_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int OUT_DAT_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOVE_DISTANCE = 3'd0,
        REG_FAST_WINDOW   = 3'd1,
        REG_COARSE_WINDOW = 3'd2,
        REG_FINE_WINDOW   = 3'd3,
        REG_HOLD_WINDOW   = 3'd4,
        REG_HOLD_COUNT    = 3'd5
    } cfg_reg_t;

    // Drive levels in percent
    localparam logic [PCT_W-1:0] PCT_FAST    = 7'd80;
    localparam logic [PCT_W-1:0] PCT_CORRECT = 7'd40;
    localparam logic [PCT_W-1:0] PCT_CREEP   = 7'd2;
    localparam logic [PCT_W-1:0] PCT_ZERO    = 7'd0;

    // Register reset values
    localparam logic [WIN_W-1:0] FAST_WINDOW_RST   = 16'd2000;
    localparam logic [WIN_W-1:0] COARSE_WINDOW_RST = 16'd400;
    localparam logic [WIN_W-1:0] FINE_WINDOW_RST   = 16'd20;
    localparam logic [WIN_W-1:0] HOLD_WINDOW_RST   = 16'd12;
    localparam logic [CNT_W-1:0] HOLD_COUNT_RST    = 8'd10;

    // One result word
    typedef struct packed {
        logic             done_res;
        logic [PCT_W-1:0] drive_percent;
        logic             drive_reverse;
        logic             drive_valid;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/phased_position_move_fsm.sv =====
// Phased position move controller: input stage, phase state machine and two-word result buffer.
//
// Usage:
//   s_* channel carries one word per encoder event: s_tuser is the mode (0 begins a
//   move of the set distance from s_tdata, 1 is a position sample), s_tdata the signed position.
//   m_* channel returns exactly one result word for each input word, in order.
//   cfg_* channel writes the six tuning registers (index 0..5); writes to other
//   indexes are dropped. cfg_ready is always high; write only while the block is idle.
// Timing:
//   Each accepted word's result is registered. One word is taken in every cycle while s_tready
//   is high: the whole step is a 33-bit add and a 33-bit subtract followed by window compares
//   and the phase update, all between the input handshake and the output register.
//   A two-word output buffer (output register plus skid register) keeps s_tready
//   registered; s_tready drops only once both words are occupied.
// Reset:
//   aresetn low clears the phase machine to the fast phase with start and target at
//   zero, loads the register defaults and empties the output buffer.
// Stall:
//   While m_tready is low the current word holds on m_tdata; one more input word is
//   taken into the skid register, then input stalls until the receiver drains.
`default_nettype none
module phased_position_move_fsm
    import ppm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input words
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [POS_W-1:0]      s_tdata,   // [31:0] position
    input  wire logic                  s_tuser,   // [0] mode
    // result words
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [OUT_DAT_W-1:0]  m_tdata,   // [0] drive_valid, [1] drive_reverse,
                                                  // [8:2] drive_percent, [9] done_res
    // register writes
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        PH_FAST   = 3'd0,
        PH_COARSE = 3'd1,
        PH_FINE   = 3'd2,
        PH_HOLD   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    localparam int DIFF_W = POS_W + 1;

    // configuration registers
    logic signed [POS_W-1:0] move_distance_reg;
    logic [WIN_W-1:0]        fast_window_reg;
    logic [WIN_W-1:0]        coarse_window_reg;
    logic [WIN_W-1:0]        fine_window_reg;
    logic [WIN_W-1:0]        hold_window_reg;
    logic [CNT_W-1:0]        hold_count_reg;

    // move state
    phase_t                  phase_reg, phase_next;
    logic signed [POS_W-1:0] target_reg, target_next;
    logic                    start_below_reg, start_below_next;
    logic                    start_above_reg, start_above_next;
    logic [CNT_W-1:0]        steady_reg, steady_next;
    logic                    done_reg, done_next;

    // output buffer
    logic                    out_valid_reg;
    result_t                 out_data_reg;
    logic                    skid_valid_reg;
    result_t                 skid_data_reg;

    logic                    in_fire;
    logic                    out_free;
    result_t                 res;

    logic signed [POS_W-1:0]  pos;
    logic signed [DIFF_W-1:0] sum_ext;
    logic signed [POS_W-1:0]  tgt_sat;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] fast_w;
    logic signed [DIFF_W-1:0] corr_w;
    logic signed [DIFF_W-1:0] hold_w;
    logic [CNT_W:0]           steady_inc;
    phase_t                   phase_mid;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DAT_W - $bits(result_t)){1'b0}}, out_data_reg};

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_distance_reg <= '0;
            fast_window_reg   <= FAST_WINDOW_RST;
            coarse_window_reg <= COARSE_WINDOW_RST;
            fine_window_reg   <= FINE_WINDOW_RST;
            hold_window_reg   <= HOLD_WINDOW_RST;
            hold_count_reg    <= HOLD_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MOVE_DISTANCE: move_distance_reg <= cfg_data;
                REG_FAST_WINDOW:   fast_window_reg   <= cfg_data[WIN_W-1:0];
                REG_COARSE_WINDOW: coarse_window_reg <= cfg_data[WIN_W-1:0];
                REG_FINE_WINDOW:   fine_window_reg   <= cfg_data[WIN_W-1:0];
                REG_HOLD_WINDOW:   hold_window_reg   <= cfg_data[WIN_W-1:0];
                REG_HOLD_COUNT:    hold_count_reg    <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // arithmetic on the incoming position
    always_comb begin
        pos     = s_tdata;
        sum_ext = DIFF_W'(pos) + DIFF_W'(move_distance_reg);
        // saturate the target to the signed 32-bit range
        if (sum_ext[DIFF_W-1] != sum_ext[DIFF_W-2]) begin
            tgt_sat = sum_ext[DIFF_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                        : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            tgt_sat = sum_ext[POS_W-1:0];
        end
        diff       = DIFF_W'(pos) - DIFF_W'(target_reg);
        fast_w     = $signed({{(DIFF_W-WIN_W){1'b0}}, fast_window_reg});
        hold_w     = $signed({{(DIFF_W-WIN_W){1'b0}}, hold_window_reg});
        steady_inc = {1'b0, steady_reg} + 1'b1;
    end

    // phase step and result
    always_comb begin
        phase_next       = phase_reg;
        target_next      = target_reg;
        start_below_next = start_below_reg;
        start_above_next = start_above_reg;
        steady_next      = steady_reg;
        done_next        = done_reg;
        res              = '0;
        phase_mid        = phase_reg;
        corr_w           = '0;

        if (!s_tuser) begin
            // begin a move
            target_next      = tgt_sat;
            start_below_next = pos < tgt_sat;
            start_above_next = pos > tgt_sat;
            phase_next       = PH_FAST;
            steady_next      = '0;
            done_next        = 1'b0;
            res.drive_valid   = 1'b1;
            res.drive_reverse = !(pos < tgt_sat);
            res.drive_percent = PCT_FAST;
        end else begin
            // leave the fast phase once inside the fast window from the start side
            if (phase_reg == PH_FAST) begin
                if ((start_below_reg && diff > -fast_w) ||
                    (start_above_reg && diff < fast_w)) begin
                    phase_mid = PH_COARSE;
                end
            end
            corr_w = $signed({{(DIFF_W-WIN_W){1'b0}},
                              (phase_mid == PH_COARSE) ? coarse_window_reg
                                                       : fine_window_reg});
            case (phase_mid)
                PH_FAST: ;
                PH_COARSE, PH_FINE: begin
                    if (diff > corr_w) begin
                        res.drive_valid   = 1'b1;
                        res.drive_reverse = 1'b1;
                        res.drive_percent = PCT_CORRECT;
                    end else if (diff < -corr_w) begin
                        res.drive_valid   = 1'b1;
                        res.drive_percent = PCT_CORRECT;
                    end else begin
                        phase_mid = (phase_mid == PH_COARSE) ? PH_FINE : PH_HOLD;
                    end
                end
                PH_HOLD: begin
                    res.drive_valid = 1'b1;
                    if (diff > hold_w) begin
                        res.drive_reverse = 1'b1;
                        res.drive_percent = PCT_CREEP;
                        steady_next       = '0;
                    end else if (diff < -hold_w) begin
                        res.drive_percent = PCT_CREEP;
                        steady_next       = '0;
                    end else begin
                        res.drive_percent = PCT_ZERO;
                        if (steady_inc > {1'b0, hold_count_reg}) begin
                            phase_mid = PH_DONE;
                        end
                        steady_next = steady_inc[CNT_W] ? {CNT_W{1'b1}}
                                                        : steady_inc[CNT_W-1:0];
                    end
                end
                default: begin
                    // complete, and any unused code
                    done_next         = 1'b1;
                    res.drive_valid   = 1'b1;
                    res.drive_percent = PCT_ZERO;
                end
            endcase
            phase_next = phase_mid;
        end
        res.done_res = done_next;
    end

    // hold move state and the output buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_FAST;
            target_reg      <= '0;
            start_below_reg <= 1'b0;
            start_above_reg <= 1'b0;
            steady_reg      <= '0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            if (in_fire) begin
                phase_reg       <= phase_next;
                target_reg      <= target_next;
                start_below_reg <= start_below_next;
                start_above_reg <= start_above_next;
                steady_reg      <= steady_next;
                done_reg        <= done_next;
            end
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_data_reg   <= skid_data_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else if (in_fire) begin
                    out_data_reg  <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (in_fire) begin
                skid_data_reg  <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ppm_checker.sv =====
// Port-level checks of the phased position move controller, bound to its top level.
`default_nettype none
module ppm_checker
    import ppm_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OUT_DAT_W-1:0] m_tdata
);

    // reset empties the output buffer
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

    // no command means zero direction and zero speed
    a_no_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'd0))
        else $error("direction or speed set without a drive command");

    // only the four drive levels are issued
    a_pct_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:2] == PCT_ZERO || m_tdata[8:2] == PCT_CREEP ||
                      m_tdata[8:2] == PCT_CORRECT || m_tdata[8:2] == PCT_FAST))
        else $error("drive percent outside the drive levels");

    // a completed move commands zero drive
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> (m_tdata[0] && m_tdata[8:1] == 8'd0))
        else $error("completed move still drives");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

endmodule

bind phased_position_move_fsm ppm_checker u_ppm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
